>>> rtl/knn_ring_average_upscaler_macros.svh
// Assertion macros for the ring-average upscaler.
`ifndef KNN_RING_AVERAGE_UPSCALER_MACROS_SVH
`define KNN_RING_AVERAGE_UPSCALER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KNNRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knnru assertion failed");
`define KNNRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knnru assertion failed");
`else
`define KNNRU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KNNRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/knnru_pkg.sv
// Shared types and constants for the ring-average upscaler.
package knnru_pkg;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_K_DEF      = 64;

    localparam int CFG_W = 9;   // config data width
    localparam int POS_W = 11;  // coordinate field width
    localparam int CH_W  = 8;   // color channel width
    localparam int CW    = 14;  // signed ring coordinate width

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_NEIGHBOURS,
        CFG_SCALE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIV_X,
        DIV_Y,
        DIV_R,
        DIV_G,
        DIV_B
    } t_div_sel;

    typedef struct packed {
        logic     wr_px;
        logic     latch_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap;
        t_div_sel cap_sel;
        logic     walk_init;
        logic     walk_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_done;
        logic short_k;
    } t_sts;
endpackage

>>> rtl/knnru_div.sv
// Restoring divider, one quotient bit per cycle.
module knnru_div #(
    parameter int DVW = 16,
    parameter int DSW = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_num,
    input  logic [DSW-1:0] i_den,
    output logic           o_done,
    output logic [DVW-1:0] o_quo
);
    localparam int CNTW = $clog2(DVW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DSW-1:0]  r_rem;
    logic [DSW-1:0]  r_den;
    logic [DVW-1:0]  r_quo;
    logic [DSW:0]    w_sh;
    logic [DSW:0]    w_diff;
    logic            w_ge;
    logic [DSW-1:0]  n_rem;
    logic [DVW-1:0]  n_quo;

    always_comb begin
        w_sh   = {r_rem, r_quo[DVW-1]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
        n_rem  = w_ge ? w_diff[DSW-1:0] : w_sh[DSW-1:0];
        n_quo  = {r_quo[DVW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DVW - 1);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> rtl/knnru_dp.sv
// Datapath: config registers, frame store, ring walker, accumulators, divider.
module knnru_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_K      = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  knnru_pkg::t_cfg_idx               i_cfg_index,
    input  logic [knnru_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [knnru_pkg::POS_W-1:0]       i_pos_x,
    input  logic [knnru_pkg::POS_W-1:0]       i_pos_y,
    input  logic [knnru_pkg::CH_W-1:0]        i_in_red,
    input  logic [knnru_pkg::CH_W-1:0]        i_in_green,
    input  logic [knnru_pkg::CH_W-1:0]        i_in_blue,
    input  knnru_pkg::t_cmd                   i_cmd,
    output knnru_pkg::t_sts                   o_sts,
    output logic [knnru_pkg::CH_W-1:0]        o_out_red,
    output logic [knnru_pkg::CH_W-1:0]        o_out_green,
    output logic [knnru_pkg::CH_W-1:0]        o_out_blue,
    output logic                              o_radius_error
);
    import knnru_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int SW    = CH_W + KW;
    localparam int DVW   = (SW > POS_W) ? SW : POS_W;
    localparam int DSW   = (KW > 4) ? KW : 4;

    // configuration
    logic [CFG_W-1:0] r_src_w;
    logic [CFG_W-1:0] r_src_h;
    logic [6:0]       r_ncnt;
    logic [3:0]       r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(64);
            r_src_h <= CFG_W'(64);
            r_ncnt  <= 7'd9;
            r_scale <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_NEIGHBOURS: r_ncnt  <= i_cfg_data[6:0];
                CFG_SCALE:      r_scale <= i_cfg_data[3:0];
                default:        r_scale <= r_scale;
            endcase
        end
    end

    logic [CW-1:0] w_w_eff;
    logic [CW-1:0] w_h_eff;
    logic [CW-1:0] w_max_rad;
    logic [KW-1:0] w_k_eff;
    logic [3:0]    w_s_eff;

    always_comb begin
        w_w_eff = (CW'(r_src_w) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(r_src_w);
        w_h_eff = (CW'(r_src_h) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(r_src_h);
        w_max_rad = w_w_eff >> 1;
        if (r_ncnt == '0)
            w_k_eff = KW'(1);
        else if (9'(r_ncnt) > 9'(MAX_K))
            w_k_eff = KW'(MAX_K);
        else
            w_k_eff = KW'(r_ncnt);
        w_s_eff = (r_scale == '0) ? 4'd1 : r_scale;
    end

    // frame store
    logic [3*CH_W-1:0] r_mem [DEPTH];
    logic [3*CH_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              w_wr_ok;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic              w_take;

    assign w_wr_ok   = (CW'(i_pos_x) < CW'(MAX_WIDTH)) && (CW'(i_pos_y) < CW'(MAX_HEIGHT));
    assign w_wr_addr = AW'(i_pos_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_pos_x[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_px && w_wr_ok)
            r_mem[w_wr_addr] <= {i_in_red, i_in_green, i_in_blue};
    end

    always_ff @(posedge i_clk) begin
        if (w_take)
            r_rd_data <= r_mem[w_rd_addr];
    end

    // ring walker
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic [CW-1:0]        r_cx;
    logic [CW-1:0]        r_cy;
    logic [CW-1:0]        r_r;
    logic [CW-1:0]        r_j;
    logic [CW-1:0]        r_p;
    logic                 r_ph;
    logic [KW-1:0]        r_found;
    logic [SW-1:0]        r_acc_r;
    logic [SW-1:0]        r_acc_g;
    logic [SW-1:0]        r_acc_b;
    logic [CH_W-1:0]      r_avg_r;
    logic [CH_W-1:0]      r_avg_g;
    logic [CH_W-1:0]      r_avg_b;
    logic [CW-1:0]        w_side;
    logic                 w_edge;
    logic signed [CW-1:0] w_x;
    logic signed [CW-1:0] w_y;
    logic signed [CW-1:0] w_top;
    logic                 w_inb;
    logic                 w_short;

    always_comb begin
        w_side = {r_r[CW-2:0], 1'b0};
        w_edge = (r_j == '0) || (r_j == w_side);
        w_top  = $signed(r_cy) - $signed(r_r);
        w_x    = $signed(r_cx) - $signed(r_r) + $signed(r_j);
        if (w_edge)
            w_y = w_top + $signed(r_p);
        else if (r_ph)
            w_y = $signed(r_cy) + $signed(r_r);
        else
            w_y = w_top;
        w_inb = !w_x[CW-1] && !w_y[CW-1]
            && ($unsigned(w_x) < w_w_eff) && ($unsigned(w_y) < w_h_eff);
        w_short = (r_found < w_k_eff);
        w_take  = i_cmd.walk_step && w_inb && w_short;
        w_rd_addr = AW'(w_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(w_x[XW-1:0]);
    end

    // divider
    logic [DVW-1:0] w_num;
    logic [DSW-1:0] w_den;
    logic           w_div_done;
    logic [DVW-1:0] w_quo;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_X: begin
                w_num = DVW'(r_px);
                w_den = DSW'(w_s_eff);
            end
            DIV_Y: begin
                w_num = DVW'(r_py);
                w_den = DSW'(w_s_eff);
            end
            DIV_R: begin
                w_num = DVW'(r_acc_r);
                w_den = DSW'(w_k_eff);
            end
            DIV_G: begin
                w_num = DVW'(r_acc_g);
                w_den = DSW'(w_k_eff);
            end
            DIV_B: begin
                w_num = DVW'(r_acc_b);
                w_den = DSW'(w_k_eff);
            end
            default: begin
                w_num = '0;
                w_den = DSW'(1);
            end
        endcase
    end

    knnru_div #(
        .DVW(DVW),
        .DSW(DSW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.cap) begin
            unique case (i_cmd.cap_sel)
                DIV_X:   r_cx    <= CW'(w_quo[POS_W-1:0]);
                DIV_Y:   r_cy    <= CW'(w_quo[POS_W-1:0]);
                DIV_R:   r_avg_r <= w_quo[CH_W-1:0];
                DIV_G:   r_avg_g <= w_quo[CH_W-1:0];
                DIV_B:   r_avg_b <= w_quo[CH_W-1:0];
                default: r_avg_b <= r_avg_b;
            endcase
        end
        if (i_cmd.walk_init) begin
            r_r     <= '0;
            r_j     <= '0;
            r_p     <= '0;
            r_ph    <= 1'b0;
            r_found <= '0;
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else begin
            if (i_cmd.walk_step) begin
                // edge columns run top to bottom, inner columns give top then bottom
                if (w_edge && (r_p != w_side)) begin
                    r_p <= r_p + 1'b1;
                end else if (!w_edge && !r_ph) begin
                    r_ph <= 1'b1;
                end else begin
                    r_ph <= 1'b0;
                    r_p  <= '0;
                    if (r_j == w_side) begin
                        r_j <= '0;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            if (w_take)
                r_found <= r_found + 1'b1;
            if (r_rd_vld) begin
                r_acc_r <= r_acc_r + SW'(r_rd_data[3*CH_W-1:2*CH_W]);
                r_acc_g <= r_acc_g + SW'(r_rd_data[2*CH_W-1:CH_W]);
                r_acc_b <= r_acc_b + SW'(r_rd_data[CH_W-1:0]);
            end
        end
        if (i_cmd.out_load) begin
            o_out_red      <= w_short ? '0 : r_avg_r;
            o_out_green    <= w_short ? '0 : r_avg_g;
            o_out_blue     <= w_short ? '0 : r_avg_b;
            o_radius_error <= w_short;
        end
    end

    always_comb begin
        o_sts.div_done  = w_div_done;
        o_sts.short_k   = w_short;
        // radius zero is the centre itself and always gets its turn
        o_sts.walk_done = !w_short || ((r_r != '0) && (r_r >= w_max_rad));
    end
endmodule

>>> rtl/knnru_ctrl.sv
// Controller: sequences load, coordinate divide, ring walk, averaging, output.
module knnru_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  knnru_pkg::t_sts i_sts,
    output knnru_pkg::t_cmd o_cmd
);
    import knnru_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIVX,
        S_DIVY,
        S_INIT,
        S_WALK,
        S_DRAIN,
        S_DIVR,
        S_DIVG,
        S_DIVB,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_COMPUTE) begin
                        o_cmd.latch_in = 1'b1;
                        n_state        = S_PREP;
                    end else begin
                        o_cmd.wr_px = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_X;
                n_state         = S_DIVX;
            end
            S_DIVX: begin
                if (i_sts.div_done) begin
                    o_cmd.cap       = 1'b1;
                    o_cmd.cap_sel   = DIV_X;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_Y;
                    n_state         = S_DIVY;
                end
            end
            S_DIVY: begin
                if (i_sts.div_done) begin
                    o_cmd.cap     = 1'b1;
                    o_cmd.cap_sel = DIV_Y;
                    n_state       = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done)
                    n_state = S_DRAIN;
                else
                    o_cmd.walk_step = 1'b1;
            end
            S_DRAIN: begin
                // last read lands in the sums by now
                if (i_sts.short_k) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_R;
                    n_state         = S_DIVR;
                end
            end
            S_DIVR: begin
                if (i_sts.div_done) begin
                    o_cmd.cap       = 1'b1;
                    o_cmd.cap_sel   = DIV_R;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_G;
                    n_state         = S_DIVG;
                end
            end
            S_DIVG: begin
                if (i_sts.div_done) begin
                    o_cmd.cap       = 1'b1;
                    o_cmd.cap_sel   = DIV_G;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_B;
                    n_state         = S_DIVB;
                end
            end
            S_DIVB: begin
                if (i_sts.div_done) begin
                    o_cmd.cap     = 1'b1;
                    o_cmd.cap_sel = DIV_B;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
        end
    end
endmodule

>>> rtl/knn_ring_average_upscaler.sv
// Top level of the k-nearest ring-average image upscaler.
// Input channel (i_in_valid / o_in_stall): cmd 0 writes one RGB pixel into the
// frame store at (pos_x, pos_y) and gives no result; cmd 1 computes one output
// pixel at output coordinate (pos_x, pos_y).
// Output channel (o_out_valid / i_out_stall): one result per compute transaction,
// the channel averages of the k nearest in-bounds source pixels plus radius_error.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): register index and data.
// Loads stream back to back.
// A compute runs two coordinate divides on the serial divider (15 bits wide at
// default sizes), a one-read-per-cycle walk over the rings of the frame store,
// then three channel divides; a radius error skips the three channel divides.
// The walk visits k ring positions for a centre well inside the image, and the
// number grows toward 4*r*r when the centre lies outside it.
// A finished result sits in the output register; while it is stalled the block
// still takes loads, and a new compute waits in its output step until the
// register frees. Reset returns config registers to their defaults and empties
// the output; the frame store keeps no reset value and must be loaded first.
`include "knn_ring_average_upscaler_macros.svh"
module knn_ring_average_upscaler #(
    parameter int MAX_WIDTH  = knnru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = knnru_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_K      = knnru_pkg::MAX_K_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [knnru_pkg::POS_W-1:0] i_pos_x,
    input  logic [knnru_pkg::POS_W-1:0] i_pos_y,
    input  logic [knnru_pkg::CH_W-1:0]  i_in_red,
    input  logic [knnru_pkg::CH_W-1:0]  i_in_green,
    input  logic [knnru_pkg::CH_W-1:0]  i_in_blue,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [knnru_pkg::CH_W-1:0]  o_out_red,
    output logic [knnru_pkg::CH_W-1:0]  o_out_green,
    output logic [knnru_pkg::CH_W-1:0]  o_out_blue,
    output logic                        o_radius_error,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  knnru_pkg::t_cfg_idx         i_cfg_index,
    input  logic [knnru_pkg::CFG_W-1:0] i_cfg_data
);
    import knnru_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    knnru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    knnru_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_K     (MAX_K)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_radius_error(o_radius_error)
    );

    `KNNRU_ASSERT_NEXT(a_div_not_instant, i_clk, i_rst_n, w_cmd.div_start, !w_sts.div_done)
    `KNNRU_ASSERT_SAME(a_no_input_in_walk, i_clk, i_rst_n, w_cmd.walk_step, o_in_stall)
    `KNNRU_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.out_load, o_out_valid)
endmodule

>>> verif/tb_knn_ring_average_upscaler.sv
// Testbench for the k-nearest ring-average upscaler: random loads and computes, scoreboard check.
`timescale 1ns / 1ps

module tb_knn_ring_average_upscaler;
    import knnru_pkg::*;

    localparam int STORE_W = MAX_WIDTH_DEF;
    localparam int STORE_H = MAX_HEIGHT_DEF;
    localparam int K_LIMIT = MAX_K_DEF;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            err;
    } t_pixel_avg;

    class knn_scoreboard;
        logic [23:0]  frame [0:STORE_W*STORE_H-1];
        int unsigned  img_w = 64;
        int unsigned  img_h = 64;
        int unsigned  k_req = 9;
        int unsigned  zoom  = 2;
        int unsigned  sum_r, sum_g, sum_b, hits;
        t_pixel_avg   pending_q[$];
        int           mismatches;

        function void write_reg(t_cfg_idx idx, int unsigned val);
            case (idx)
                CFG_SRC_WIDTH:  img_w = val & 9'h1FF;
                CFG_SRC_HEIGHT: img_h = val & 9'h1FF;
                CFG_NEIGHBOURS: k_req = val & 7'h7F;
                CFG_SCALE:      zoom  = val & 4'hF;
                default: ;
            endcase
        endfunction

        function void gather(int x, int y, int w, int h, int unsigned k);
            logic [23:0] px;
            if (hits >= k || x < 0 || y < 0 || x >= w || y >= h) return;
            px = frame[y*STORE_W + x];
            sum_r += px[23:16];
            sum_g += px[15:8];
            sum_b += px[7:0];
            hits++;
        endfunction

        // Accepted input transaction: store write or expected average.
        function void note_input(logic cmd, int unsigned x, int unsigned y,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int w, h, cx, cy, rad, side, j, p;
            int unsigned k, s;
            t_pixel_avg e;
            if (cmd == CMD_LOAD) begin
                if (x < STORE_W && y < STORE_H) frame[y*STORE_W + x] = {r, g, b};
                return;
            end
            w = (img_w > STORE_W) ? STORE_W : img_w;
            h = (img_h > STORE_H) ? STORE_H : img_h;
            k = (k_req < 1) ? 1 : (k_req > K_LIMIT) ? K_LIMIT : k_req;
            s = (zoom == 0) ? 1 : zoom;
            cx = x / s;
            cy = y / s;
            sum_r = 0; sum_g = 0; sum_b = 0; hits = 0;
            gather(cx, cy, w, h, k);
            for (rad = 1; hits < k && rad < w / 2; rad++) begin
                side = 2 * rad;
                for (j = 0; j <= side; j++) begin
                    if (j == 0 || j == side) begin
                        for (p = 0; p <= side; p++) gather(cx - rad + j, cy - rad + p, w, h, k);
                    end else begin
                        gather(cx - rad + j, cy - rad, w, h, k);
                        gather(cx - rad + j, cy + rad, w, h, k);
                    end
                end
            end
            if (hits < k) begin
                e = '{8'd0, 8'd0, 8'd0, 1'b1};
            end else begin
                e.red   = CH_W'(sum_r / k);
                e.green = CH_W'(sum_g / k);
                e.blue  = CH_W'(sum_b / k);
                e.err   = 1'b0;
            end
            pending_q.push_back(e);
        endfunction

        function void flag(string what, int exp_v, int act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, act_v);
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic err);
            t_pixel_avg e;
            if (pending_q.size() == 0) begin
                flag("unexpected result, red", -1, r);
                return;
            end
            e = pending_q.pop_front();
            if (r !== e.red)   flag("red", e.red, r);
            if (g !== e.green) flag("green", e.green, g);
            if (b !== e.blue)  flag("blue", e.blue, b);
            if (err !== e.err) flag("radius_error", e.err, err);
        endfunction
    endclass

    logic                i_clk, i_rst_n;
    logic                i_in_valid, o_in_stall, i_cmd;
    logic [POS_W-1:0]    i_pos_x, i_pos_y;
    logic [CH_W-1:0]     i_in_red, i_in_green, i_in_blue;
    logic                o_out_valid, i_out_stall;
    logic [CH_W-1:0]     o_out_red, o_out_green, o_out_blue;
    logic                o_radius_error;
    logic                i_cfg_valid, o_cfg_ready;
    t_cfg_idx            i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    knn_ring_average_upscaler uut (.*);

    knn_scoreboard sb = new();
    bit            gaps_on  = 1;
    bit            stall_on = 1;
    int            stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver back-pressure: runs of free flow, short stalls, rare long stalls.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_on || $urandom_range(0, 9) < 6) begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 20);
        end else begin
            i_out_stall <= 1'b1;
            stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_red, o_out_green, o_out_blue, o_radius_error);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (!gaps_on || roll < 4) return 0;
        if (roll < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(logic cmd, int unsigned x, int unsigned y,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd; i_pos_x = POS_W'(x); i_pos_y = POS_W'(y);
        i_in_red = r; i_in_green = g; i_in_blue = b;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, x, y, r, g, b);
        @(negedge i_clk);
    endtask

    task automatic load_px(int unsigned x, int unsigned y);
        send_item(CMD_LOAD, x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    task automatic compute_at(int unsigned x, int unsigned y);
        send_item(CMD_COMPUTE, x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    // Sender holds off until every outstanding result is back, plus slack.
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(val);
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_image(int unsigned w, int unsigned h, int unsigned k, int unsigned s);
        drain();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_NEIGHBOURS, k);
        write_reg(CFG_SCALE, s);
    endtask

    initial begin
        int unsigned w, h, k, s;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_cmd = CMD_LOAD;
        i_pos_x = '0; i_pos_y = '0; i_in_red = '0; i_in_green = '0; i_in_blue = '0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_SRC_WIDTH; i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Fill the 16x16 corner plus row 0 and column 0 so no compute reads an unwritten pixel.
        gaps_on = 0;
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++) load_px(x, y);
        for (int x = 16; x < STORE_W; x++) load_px(x, 0);
        for (int y = 16; y < STORE_H; y++) load_px(0, y);
        gaps_on = 1;

        // Loads outside the store must be dropped.
        send_item(CMD_LOAD, 2047, 2047, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_LOAD, 256, 3, 8'hFF, 8'h00, 8'hFF);
        send_item(CMD_LOAD, 5, 256, 8'h00, 8'hFF, 8'h00);
        send_item(CMD_LOAD, 15, 15, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_LOAD, 0, 0, 8'h00, 8'h00, 8'h00);

        set_image(16, 16, 1, 1);
        compute_at(0, 0); compute_at(15, 15); compute_at(2047, 2047);
        set_image(16, 16, 0, 0);
        compute_at(3, 7); compute_at(16, 2);
        set_image(16, 16, 127, 15);
        compute_at(120, 120); compute_at(0, 0); compute_at(2047, 0);
        set_image(0, 16, 4, 1);
        compute_at(1, 1);
        set_image(16, 0, 4, 1);
        compute_at(1, 1);
        // Oversized width saturates; a single row of the store is in use.
        set_image(511, 1, 64, 8);
        compute_at(0, 0); compute_at(2047, 0);
        set_image(300, 1, 64, 1);
        compute_at(2047, 0);
        set_image(1, 511, 1, 2);
        compute_at(0, 511); compute_at(0, 2047);
        set_image(2, 256, 5, 1);
        compute_at(0, 100);

        for (int n = 0; n < 650; n++) begin
            if (n % 100 == 0) begin
                w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
                case ($urandom_range(0, 5))
                    0: k = 0;
                    1: k = $urandom_range(65, 127);
                    2: k = $urandom_range(1, 64);
                    default: k = $urandom_range(1, 12);
                endcase
                s = $urandom_range(0, 15);
                set_image(w, h, k, s);
                gaps_on  = (n % 300 != 200);
                stall_on = (n % 300 != 100);
            end
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047),
                              CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
                else
                    load_px($urandom_range(0, 15), $urandom_range(0, 15));
            end else if ($urandom_range(0, 9) == 0) begin
                compute_at($urandom_range(0, 2047), $urandom_range(0, 2047));
            end else begin
                s = (sb.zoom == 0) ? 1 : sb.zoom;
                compute_at($urandom_range(0, 17 * s), $urandom_range(0, 17 * s));
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> knn_ring_average_upscaler.f
+incdir+rtl
rtl/knnru_pkg.sv
rtl/knnru_div.sv
rtl/knnru_dp.sv
rtl/knnru_ctrl.sv
rtl/knn_ring_average_upscaler.sv
verif/tb_knn_ring_average_upscaler.sv
